/* rtl/ihp_pkg.sv */
// Shared types and codes for the indexed min-heap.
// Request and response payload structs, action codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ihp_pkg;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] key;
        logic [9:0]         handle;
    } ihp_req_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] value;
        logic [9:0]         new_handle;
    } ihp_rsp_t;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_EXTRACT = 3'd1;
    localparam logic [2:0] ACT_GET     = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_CHANGE  = 3'd4;
    localparam logic [2:0] ACT_SIZE    = 3'd5;
    localparam logic [2:0] ACT_CLEAR   = 3'd6;
    localparam logic [2:0] ACT_UNUSED  = 3'd7;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TOP_WAIT,
        S_SOT_WAIT,
        S_REMOVE,
        S_LAST_WAIT,
        S_UP,
        S_UP_WAIT,
        S_DOWN,
        S_DL_WAIT,
        S_DR_WAIT,
        S_DSEL,
        S_FINAL,
        S_RESP
    } ihp_state_t;

endpackage
`default_nettype wire

/* rtl/ihp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int ADDR_BITS = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

/* rtl/indexed_min_heap.sv */
// Indexed binary min-heap top level: sequencer, heap slot RAM, handle-to-slot RAM.
// Depends on ihp_pkg and ihp_ram.
// Sifting up reads one heap RAM entry per level, sifting down up to two (both children).
// One request is in work at a time.
// Reset is synchronous, active low; no clearing pass, handles up to the clear mark read absent.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap
    import ihp_pkg::*;
#(
    parameter int SLOT_BITS = 10
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ihp_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ihp_rsp_t      m_data
);
    localparam int SB = SLOT_BITS;
    localparam int HW = 32 + SB;
    localparam logic [SB-1:0] CAP = {SB{1'b1}};
    localparam logic [SB-1:0] ONE = SB'(1);

    ihp_state_t state_reg, state_next;

    logic [2:0]         act_reg, act_next;
    logic signed [31:0] key_reg, key_next;
    logic [SB-1:0]      hdl_reg, hdl_next;
    logic [SB-1:0]      count_reg, count_next;
    logic [SB-1:0]      issued_reg, issued_next;
    logic [SB-1:0]      mark_reg, mark_next;
    logic [SB-1:0]      slot_reg, slot_next;
    logic signed [31:0] ikey_reg, ikey_next;
    logic [SB-1:0]      iown_reg, iown_next;
    logic signed [31:0] bkey_reg, bkey_next;
    logic [SB-1:0]      bown_reg, bown_next;
    logic [SB-1:0]      bslot_reg, bslot_next;
    logic               moved_reg, moved_next;
    ihp_rsp_t           rsp_reg, rsp_next;
    ihp_rsp_t           out_reg, out_next;
    logic               mv_reg, mv_next;

    logic          h_we;
    logic [SB-1:0] h_waddr, h_raddr;
    logic [HW-1:0] h_wdata, h_rdata;
    logic          t_we;
    logic [SB-1:0] t_waddr, t_raddr, t_wdata, t_rdata;

    logic signed [31:0] rkey;
    logic [SB-1:0]      rown;
    logic [SB:0]        l_slot, r_slot;
    logic signed [31:0] cmp_key;
    logic [31:0]        iss32, cnt32;
    logic               full, hdl_ok;

    assign rkey    = h_rdata[SB +: 32];
    assign rown    = h_rdata[SB-1:0];
    assign l_slot  = {slot_reg, 1'b0};
    assign r_slot  = {slot_reg, 1'b1};
    assign cmp_key = moved_reg ? bkey_reg : ikey_reg;
    assign iss32   = 32'(issued_reg + ONE);
    assign cnt32   = 32'(count_reg);
    assign full    = (count_reg == CAP) || (issued_reg == CAP);
    assign hdl_ok  = (hdl_reg != '0) && (hdl_reg > mark_reg) && (hdl_reg <= issued_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    ihp_ram #(.WIDTH(HW), .ADDR_BITS(SB)) u_heap_ram (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    ihp_ram #(.WIDTH(SB), .ADDR_BITS(SB)) u_slot_ram (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (act_reg) inside
                    ACT_INSERT:              state_next = full ? S_RESP : S_UP;
                    ACT_EXTRACT, ACT_GET:    state_next = (count_reg == '0) ? S_RESP : S_TOP_WAIT;
                    ACT_DELETE, ACT_CHANGE:  state_next = hdl_ok ? S_SOT_WAIT : S_RESP;
                    default:                 state_next = S_RESP;
                endcase
            end
            S_TOP_WAIT:  state_next = (act_reg == ACT_GET) ? S_RESP : S_REMOVE;
            S_SOT_WAIT: begin
                if (t_rdata == '0) state_next = S_RESP;
                else if (act_reg == ACT_CHANGE) state_next = S_UP;
                else state_next = S_REMOVE;
            end
            S_REMOVE:    state_next = (slot_reg == count_reg) ? S_RESP : S_LAST_WAIT;
            S_LAST_WAIT: state_next = S_UP;
            S_UP:        state_next = (slot_reg == ONE) ? S_DOWN : S_UP_WAIT;
            S_UP_WAIT:   state_next = (ikey_reg < rkey) ? S_UP : S_DOWN;
            S_DOWN:      state_next = (l_slot > {1'b0, count_reg}) ? S_FINAL : S_DL_WAIT;
            S_DL_WAIT:   state_next = (r_slot > {1'b0, count_reg}) ? S_DSEL : S_DR_WAIT;
            S_DR_WAIT:   state_next = S_DSEL;
            S_DSEL:      state_next = moved_reg ? S_DOWN : S_FINAL;
            S_FINAL:     state_next = S_RESP;
            S_RESP: begin
                if (!mv_reg || m_ready) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        act_next    = act_reg;
        key_next    = key_reg;
        hdl_next    = hdl_reg;
        count_next  = count_reg;
        issued_next = issued_reg;
        mark_next   = mark_reg;
        slot_next   = slot_reg;
        ikey_next   = ikey_reg;
        iown_next   = iown_reg;
        bkey_next   = bkey_reg;
        bown_next   = bown_reg;
        bslot_next  = bslot_reg;
        moved_next  = moved_reg;
        rsp_next    = rsp_reg;
        out_next    = out_reg;
        mv_next     = mv_reg;
        h_we        = 1'b0;
        h_waddr     = slot_reg;
        h_wdata     = {ikey_reg, iown_reg};
        h_raddr     = '0;
        t_we        = 1'b0;
        t_waddr     = iown_reg;
        t_wdata     = slot_reg;
        t_raddr     = hdl_reg;

        if (mv_reg && m_ready) mv_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next = s_data.action;
                    key_next = s_data.key;
                    hdl_next = SB'(s_data.handle);
                end
            end
            S_DECODE: begin
                rsp_next = '{status: ST_OK, value: '0, new_handle: '0};
                h_raddr  = ONE;
                unique case (act_reg) inside
                    ACT_INSERT: begin
                        if (full) begin
                            rsp_next.status = ST_ERR;
                        end else begin
                            issued_next         = issued_reg + ONE;
                            count_next          = count_reg + ONE;
                            slot_next           = count_reg + ONE;
                            ikey_next           = key_reg;
                            iown_next           = issued_reg + ONE;
                            rsp_next.new_handle = iss32[9:0];
                        end
                    end
                    ACT_EXTRACT, ACT_GET: begin
                        if (count_reg == '0) rsp_next.status = ST_ERR;
                    end
                    ACT_DELETE, ACT_CHANGE: begin
                        if (!hdl_ok) rsp_next.status = ST_ERR;
                    end
                    ACT_SIZE:  rsp_next.value = cnt32;
                    ACT_CLEAR: begin
                        count_next = '0;
                        mark_next  = issued_reg;
                    end
                    default:   rsp_next.status = ST_ERR;
                endcase
            end
            S_TOP_WAIT: begin
                rsp_next.value = rkey;
                hdl_next       = rown;
                slot_next      = ONE;
            end
            S_SOT_WAIT: begin
                slot_next = t_rdata;
                ikey_next = key_reg;
                iown_next = hdl_reg;
                if (t_rdata == '0) rsp_next.status = ST_ERR;
            end
            S_REMOVE: begin
                t_we    = 1'b1;
                t_waddr = hdl_reg;
                t_wdata = '0;
                h_raddr = count_reg;
                if (slot_reg == count_reg) count_next = count_reg - ONE;
            end
            S_LAST_WAIT: begin
                ikey_next  = rkey;
                iown_next  = rown;
                count_next = count_reg - ONE;
            end
            S_UP: begin
                h_raddr = slot_reg >> 1;
            end
            S_UP_WAIT: begin
                if (ikey_reg < rkey) begin
                    h_we      = 1'b1;
                    h_wdata   = h_rdata;
                    t_we      = 1'b1;
                    t_waddr   = rown;
                    t_wdata   = slot_reg;
                    slot_next = slot_reg >> 1;
                end
            end
            S_DOWN: begin
                h_raddr = l_slot[SB-1:0];
            end
            S_DL_WAIT: begin
                h_raddr    = r_slot[SB-1:0];
                moved_next = (rkey < ikey_reg);
                bkey_next  = rkey;
                bown_next  = rown;
                bslot_next = l_slot[SB-1:0];
            end
            S_DR_WAIT: begin
                if (rkey < cmp_key) begin
                    moved_next = 1'b1;
                    bkey_next  = rkey;
                    bown_next  = rown;
                    bslot_next = r_slot[SB-1:0];
                end
            end
            S_DSEL: begin
                if (moved_reg) begin
                    h_we      = 1'b1;
                    h_wdata   = {bkey_reg, bown_reg};
                    t_we      = 1'b1;
                    t_waddr   = bown_reg;
                    t_wdata   = slot_reg;
                    slot_next = bslot_reg;
                end
            end
            S_FINAL: begin
                h_we = 1'b1;
                t_we = 1'b1;
            end
            S_RESP: begin
                if (!mv_reg || m_ready) begin
                    out_next = rsp_reg;
                    mv_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            issued_reg <= '0;
            mark_reg   <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issued_reg <= issued_next;
            mark_reg   <= mark_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        hdl_reg   <= hdl_next;
        slot_reg  <= slot_next;
        ikey_reg  <= ikey_next;
        iown_reg  <= iown_next;
        bkey_reg  <= bkey_next;
        bown_reg  <= bown_next;
        bslot_reg <= bslot_next;
        moved_reg <= moved_next;
        rsp_reg   <= rsp_next;
        out_reg   <= out_next;
    end
endmodule
`default_nettype wire

/* bench/indexed_min_heap_tb.sv */
// Self-checking bench for the indexed min-heap: random and directed requests,
// a behavioral heap predictor, and field-by-field response checking.
// Depends on ihp_pkg and the indexed_min_heap RTL.
`timescale 1ns / 1ps
module indexed_min_heap_tb;
    import ihp_pkg::*;

    localparam int CAP = 1023;
    localparam int CYCLE_LIMIT = 1500000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ihp_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ihp_rsp_t m_data;

    indexed_min_heap DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic signed [31:0] hk [0:CAP];
    int                 ho [0:CAP];
    int                 hslot [0:CAP];
    int                 cnt;
    int                 issued;

    ihp_req_t pending_reqs [$];
    ihp_rsp_t expected_rsps [$];
    int       errors = 0;
    int       cycles = 0;
    bit       hold_sender = 0;
    bit       s_taken = 0;
    int       s_gap = 0;
    int       m_gap = 0;
    int       plan_issued = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, exp);
    endtask

    function automatic void swap_slots(input int a, input int b);
        logic signed [31:0] k;
        int o;
        k = hk[a]; o = ho[a];
        hk[a] = hk[b]; ho[a] = ho[b];
        hk[b] = k; ho[b] = o;
        hslot[ho[a]] = a;
        hslot[ho[b]] = b;
    endfunction

    function automatic void sift_up(input int s);
        while (s > 1 && hk[s] < hk[s / 2]) begin
            swap_slots(s, s / 2);
            s = s / 2;
        end
    endfunction

    function automatic void push_down(input int s);
        int l, m;
        forever begin
            l = 2 * s; m = s;
            if (l <= cnt && hk[l] < hk[m]) m = l;
            if (l + 1 <= cnt && hk[l + 1] < hk[m]) m = l + 1;
            if (m == s) return;
            swap_slots(s, m);
            s = m;
        end
    endfunction

    function automatic void remove_entry(input int h);
        int s;
        s = hslot[h];
        hslot[h] = 0;
        if (s != cnt) begin
            hk[s] = hk[cnt]; ho[s] = ho[cnt];
            hslot[ho[s]] = s;
            cnt--;
            sift_up(s);
            push_down(s);
        end else begin
            cnt--;
        end
    endfunction

    function automatic ihp_rsp_t heap_step(input ihp_req_t r);
        ihp_rsp_t p;
        int h;
        p = '0;
        h = r.handle;
        case (r.action) inside
            ACT_INSERT: begin
                if (cnt >= CAP || issued >= CAP) begin
                    p.status = ST_ERR;
                end else begin
                    issued++; cnt++;
                    hk[cnt] = r.key; ho[cnt] = issued; hslot[issued] = cnt;
                    sift_up(cnt);
                    p.new_handle = issued[9:0];
                end
            end
            ACT_EXTRACT, ACT_GET: begin
                if (cnt == 0) begin
                    p.status = ST_ERR;
                end else begin
                    p.value = hk[1];
                    if (r.action == ACT_EXTRACT) remove_entry(ho[1]);
                end
            end
            ACT_DELETE, ACT_CHANGE: begin
                if (h == 0 || hslot[h] == 0) begin
                    p.status = ST_ERR;
                end else if (r.action == ACT_DELETE) begin
                    remove_entry(h);
                end else begin
                    hk[hslot[h]] = r.key;
                    sift_up(hslot[h]);
                    push_down(hslot[h]);
                end
            end
            ACT_SIZE: p.value = cnt;
            ACT_CLEAR: begin
                cnt = 0;
                for (int i = 0; i <= CAP; i++) hslot[i] = 0;
            end
            default: p.status = ST_ERR;
        endcase
        return p;
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic ihp_req_t mk(input logic [2:0] a, input logic signed [31:0] k,
                                    input int h);
        ihp_req_t r;
        r.action = a; r.key = k; r.handle = h[9:0];
        return r;
    endfunction

    function automatic int pick_handle();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(plan_issued > 20 ? plan_issued - 20 : 0, plan_issued + 1);
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                expected_rsps.push_back(heap_step(s_data));
            end
            if (!s_valid || s_taken) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_sender) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_gap = next_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                m_gap = next_gap();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        ihp_rsp_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("indexed_min_heap: mismatch");
            $finish;
        end
        s_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                report("unexpected response", 64'(m_data), 64'(0));
            end else begin
                e = expected_rsps.pop_front();
                if (m_data.status !== e.status)
                    report("status", 64'(m_data.status), 64'(e.status));
                if (m_data.value !== e.value)
                    report("value", 64'(m_data.value), 64'(e.value));
                if (m_data.new_handle !== e.new_handle)
                    report("new_handle", 64'(m_data.new_handle), 64'(e.new_handle));
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0) @(posedge aclk);
    endtask

    initial begin
        int a;
        cnt = 0; issued = 0;
        for (int i = 0; i <= CAP; i++) hslot[i] = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed corners
        pending_reqs.push_back(mk(ACT_EXTRACT, 0, 0));
        pending_reqs.push_back(mk(ACT_GET, 0, 0));
        pending_reqs.push_back(mk(ACT_DELETE, 0, 1));
        pending_reqs.push_back(mk(ACT_INSERT, 32'sh7fffffff, 0));
        pending_reqs.push_back(mk(ACT_INSERT, 32'sh80000000, 1023));
        pending_reqs.push_back(mk(ACT_INSERT, 5, 0));
        pending_reqs.push_back(mk(ACT_GET, 0, 0));
        pending_reqs.push_back(mk(ACT_CHANGE, -7, 3));
        pending_reqs.push_back(mk(ACT_CHANGE, 1, 0));
        pending_reqs.push_back(mk(ACT_DELETE, 0, 0));
        pending_reqs.push_back(mk(ACT_DELETE, 0, 1023));
        pending_reqs.push_back(mk(ACT_DELETE, 0, 1));
        pending_reqs.push_back(mk(ACT_SIZE, 0, 0));
        pending_reqs.push_back(mk(ACT_EXTRACT, 0, 0));
        pending_reqs.push_back(mk(ACT_UNUSED, -1, 1023));
        pending_reqs.push_back(mk(ACT_CLEAR, 0, 0));
        pending_reqs.push_back(mk(ACT_CHANGE, 0, 2));
        pending_reqs.push_back(mk(ACT_SIZE, 0, 0));
        pending_reqs.push_back(mk(ACT_INSERT, 0, 0));
        pending_reqs.push_back(mk(ACT_DELETE, 0, 4));
        drain();
        hold_sender = 1;
        repeat (20) @(posedge aclk);
        hold_sender = 0;
        plan_issued = issued;

        // random mix, inserts dominate so the heap grows deep
        for (int n = 0; n < 1270; n++) begin
            a = $urandom_range(0, 99);
            if (a < 40) begin
                pending_reqs.push_back(mk(ACT_INSERT, rand_key(), $urandom));
                plan_issued++;
            end
            else if (a < 52) pending_reqs.push_back(mk(ACT_EXTRACT, $urandom, $urandom));
            else if (a < 58) pending_reqs.push_back(mk(ACT_GET, $urandom, $urandom));
            else if (a < 72) pending_reqs.push_back(mk(ACT_DELETE, $urandom, pick_handle()));
            else if (a < 90) pending_reqs.push_back(mk(ACT_CHANGE, rand_key(), pick_handle()));
            else if (a < 96) pending_reqs.push_back(mk(ACT_SIZE, $urandom, $urandom));
            else if (a < 98) pending_reqs.push_back(mk(ACT_CLEAR, $urandom, $urandom));
            else pending_reqs.push_back(mk(ACT_UNUSED, $urandom, $urandom));
            if (n == 900) begin
                drain();
                hold_sender = 1;
                repeat (50) @(posedge aclk);
                hold_sender = 0;
                plan_issued = issued;
            end
        end
        // exhaust the handle space so insert-when-full is hit
        drain();
        for (int n = issued; n < CAP + 2; n++)
            pending_reqs.push_back(mk(ACT_INSERT, rand_key(), 0));
        pending_reqs.push_back(mk(ACT_SIZE, 0, 0));
        for (int n = 0; n < 40; n++) pending_reqs.push_back(mk(ACT_EXTRACT, 0, 0));
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("indexed_min_heap: match");
        end else begin
            $display("indexed_min_heap: mismatch");
        end
        $finish;
    end
endmodule
